/* design/two_tap_delay_pitch_shifter_macros.svh */
// Assertion macros for the two-tap delay pitch shifter.
// Uses clk and rst_n of the module that expands them.
`ifndef TWO_TAP_DELAY_PITCH_SHIFTER_MACROS_SVH
`define TWO_TAP_DELAY_PITCH_SHIFTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TPDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TPDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tpds_pkg.sv */
// Shared constants and types for the two-tap delay pitch shifter.
// No dependencies.
`default_nettype none

package tpds_pkg;

  localparam int STORE_DEPTH = 16384;
  localparam int CHANNELS    = 2;

  localparam int FRAME_W  = $clog2(STORE_DEPTH);
  localparam int ADDR_W   = $clog2(STORE_DEPTH * CHANNELS);
  localparam int SAMPLE_W = 24;
  localparam int PHASE_W  = 32;
  localparam int GRAIN_W  = 13;
  localparam int FRAC_W   = 16;
  localparam int WGT_W    = 16;
  localparam int POS_W    = FRAME_W + FRAC_W;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int VAL_W    = SAMPLE_W + FRAC_W + 1;
  localparam int VHI_W    = VAL_W - FRAC_W;
  localparam int MA_W     = PHASE_W + 1;
  localparam int MB_W     = WGT_W + 2;
  localparam int MP_W     = MA_W + MB_W;
  localparam int ACC_W    = 58;
  localparam int TDATA_W  = 2 * SAMPLE_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_LENGTH = CFG_IDX_W'(1);
  localparam logic [GRAIN_W-1:0]   GRAIN_RESET      = GRAIN_W'(2400);

  localparam logic CH_LAST = 1'(CHANNELS - 1);

  typedef enum logic [1:0] {
    MUL_DELAY,
    MUL_INTERP,
    MUL_HIGH,
    MUL_LOW
  } mul_op_t;

  typedef struct packed {
    mul_op_t                   op;
    logic [PHASE_W-1:0]        phase;
    logic [GRAIN_W-1:0]        grain;
    logic signed [DIFF_W-1:0]  diff;
    logic [FRAC_W-1:0]         frac;
    logic signed [VHI_W-1:0]   vhi;
    logic [FRAC_W-1:0]         vlo;
    logic [WGT_W-1:0]          weight;
  } mul_req_t;

endpackage

`default_nettype wire

/* design/tpds_store.sv */
// Delay store: single-port frame memory, one access per cycle, registered read.
// Depends on tpds_pkg.
`default_nettype none

module tpds_store (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [tpds_pkg::ADDR_W-1:0]   addr,
  input  wire logic [tpds_pkg::SAMPLE_W-1:0] wdata,
  output logic      [tpds_pkg::SAMPLE_W-1:0] rdata
);
  import tpds_pkg::*;

  logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH*CHANNELS];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[addr] <= wdata;
    end
    rdata_r <= store_mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/tpds_mul.sv */
// Shared multiplier: operand select by op code, product registered.
// Depends on tpds_pkg.
`default_nettype none

module tpds_mul (
  input  wire logic                             clk,
  input  wire tpds_pkg::mul_req_t               req,
  output logic signed [tpds_pkg::MP_W-1:0]      prod
);
  import tpds_pkg::*;

  logic signed [MA_W-1:0] opa;
  logic signed [MB_W-1:0] opb;
  logic signed [MP_W-1:0] prod_r;

  always_comb begin
    unique case (req.op)
      MUL_DELAY: begin
        opa = $signed({1'b0, req.phase});
        opb = $signed({{(MB_W-GRAIN_W){1'b0}}, req.grain});
      end
      MUL_INTERP: begin
        opa = $signed({{(MA_W-DIFF_W){req.diff[DIFF_W-1]}}, req.diff});
        opb = $signed({{(MB_W-FRAC_W){1'b0}}, req.frac});
      end
      MUL_HIGH: begin
        opa = $signed({{(MA_W-VHI_W){req.vhi[VHI_W-1]}}, req.vhi});
        opb = $signed({{(MB_W-WGT_W){1'b0}}, req.weight});
      end
      MUL_LOW: begin
        opa = $signed({{(MA_W-FRAC_W){1'b0}}, req.vlo});
        opb = $signed({{(MB_W-WGT_W){1'b0}}, req.weight});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

/* design/two_tap_delay_pitch_shifter.sv */
// Two-tap delay-line pitch shifter with triangular crossfade (top level).
// Depends on tpds_pkg, tpds_store, tpds_mul and two_tap_delay_pitch_shifter_macros.svh.
//
// Usage:
//  - in_*: one transaction carries one audio frame, two Q1.23 samples.
//  - out_*: one transaction per input frame, two saturated Q1.23 samples.
//  - cfg_*: register writes (index 0 phase_step, 1 grain_length); always
//    ready, write only while the block is idle. Other indexes are dropped.
//  - Sequence: the frame is written to the store, then each tap computes its
//    delay, reads two neighbor frames per channel, interpolates and weights.
//    All products go through one shared 33x18 multiplier and all store
//    accesses through one memory port. A new frame is taken only after the
//    previous frame's result has been loaded into the output register.
//  - in_tready is high only while idle.
//  - A finished result sits in the output register; if the receiver stalls
//    and a second result is ready, the sequencer holds in its final step.
//  - Reset: cursor and phase go to zero, phase_step to 0, grain_length to
//    2400. The store is not swept: frames not yet written since reset read
//    as zero, tracked by the write cursor and a wrapped flag.
`default_nettype none

`include "two_tap_delay_pitch_shifter_macros.svh"

module two_tap_delay_pitch_shifter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: [23:0] sample_ch0, [47:24] sample_ch1
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tpds_pkg::TDATA_W-1:0]    in_tdata,
  // out_tdata: [23:0] shifted_ch0, [47:24] shifted_ch1
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [tpds_pkg::TDATA_W-1:0]    out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tpds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WR0, ST_WR1, ST_DLY, ST_POS, ST_RD1, ST_RD2, ST_RDW,
    ST_INT, ST_INTW, ST_MHI, ST_MLO, ST_ACCL, ST_FIN
  } state_t;

  localparam logic [PHASE_W-1:0] HALF = {1'b1, {(PHASE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << 30);
  localparam int Q_W = ACC_W - 31;

  // triangle window: (2^31 - |phase - 2^31|) >> 16
  function automatic logic [WGT_W-1:0] weight_of(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] d;
    logic [PHASE_W-1:0] t;
    d = ph[PHASE_W-1] ? (ph - HALF) : (HALF - ph);
    t = HALF - d;
    return t[PHASE_W-1 -: WGT_W];
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [FRAME_W-1:0] frame,
                                                  input logic ch);
    logic [FRAME_W:0] t;
    t = {frame, ch};
    return ADDR_W'(t >> (2 - CHANNELS));
  endfunction

  // round half up by 31 bits, saturate to Q1.23
  function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic [Q_W-1:0] q;
    t = acc + ROUND_BIAS;
    q = t[ACC_W-1:31];
    if (!q[Q_W-1] && (|q[Q_W-2:SAMPLE_W-1])) begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (q[Q_W-1] && !(&q[Q_W-2:SAMPLE_W-1])) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return q[SAMPLE_W-1:0];
    end
  endfunction

  state_t state_r;

  // configuration and frame state
  logic [PHASE_W-1:0]  phase_step_r;
  logic [GRAIN_W-1:0]  grain_r;
  logic [FRAME_W-1:0]  cursor_r;
  logic [FRAME_W-1:0]  cursor_inc;
  logic                full_r;      // cursor has wrapped: every frame written
  logic [PHASE_W-1:0]  phase_r;

  // per-item working registers
  logic [SAMPLE_W-1:0]        smp0_r, smp1_r;
  logic [WGT_W-1:0]           wa_r, wb_r;
  logic                       tap_r;
  logic                       ch_r;
  logic [FRAME_W-1:0]         i1_r;
  logic [FRAC_W-1:0]          frac_r;
  logic                       rd_ok_r;
  logic signed [SAMPLE_W-1:0] s1_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic [VAL_W-1:0]           val_r;
  logic signed [ACC_W-1:0]    acc_r [2];

  logic                  out_tvalid_r;
  logic [TDATA_W-1:0]    out_tdata_r;

  // datapath nets
  logic [FRAME_W-1:0]         i2;
  logic [POS_W-1:0]           pos;
  logic [PHASE_W-1:0]         tap_phase;
  logic [WGT_W-1:0]           tap_weight;
  logic signed [SAMPLE_W-1:0] rd_smp;
  logic signed [MP_W-1:0]     prod;
  mul_req_t                   mreq;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_a;
  logic [SAMPLE_W-1:0]        mem_wd;
  logic [SAMPLE_W-1:0]        mem_rd;
  logic                       in_acc;
  logic                       fin_go;
  logic                       rd_frame_ok;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign fin_go     = (state_r == ST_FIN) && (!out_tvalid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign cursor_inc = cursor_r + 1'b1;
  assign i2         = i1_r + 1'b1;
  assign tap_phase  = tap_r ? (phase_r + HALF) : phase_r;
  assign tap_weight = tap_r ? wb_r : wa_r;
  // read position = cursor - delay, Q.16, wraps at the store depth
  assign pos        = {cursor_r, {FRAC_W{1'b0}}} - prod[FRAC_W +: POS_W];
  assign rd_smp     = rd_ok_r ? $signed(mem_rd) : '0;

  // frames beyond the cursor have not been written since reset until the wrap
  always_comb begin
    if (state_r == ST_RD2) begin
      rd_frame_ok = full_r || (i2 <= cursor_r);
    end else begin
      rd_frame_ok = full_r || (i1_r <= cursor_r);
    end
  end

  // store port
  always_comb begin
    mem_we = 1'b0;
    mem_wd = smp0_r;
    mem_a  = mem_addr(i1_r, ch_r);
    unique case (state_r)
      ST_WR0: begin
        mem_we = 1'b1;
        mem_a  = mem_addr(cursor_r, 1'b0);
      end
      ST_WR1: begin
        mem_we = 1'b1;
        mem_wd = smp1_r;
        mem_a  = mem_addr(cursor_r, 1'b1);
      end
      ST_RD2:  mem_a = mem_addr(i2, ch_r);
      default: mem_a = mem_addr(i1_r, ch_r);
    endcase
  end

  // multiplier request
  always_comb begin
    mreq.phase  = tap_phase;
    mreq.grain  = grain_r;
    mreq.diff   = diff_r;
    mreq.frac   = frac_r;
    mreq.vhi    = $signed(val_r[VAL_W-1:FRAC_W]);
    mreq.vlo    = val_r[FRAC_W-1:0];
    mreq.weight = tap_weight;
    unique case (state_r)
      ST_INT:  mreq.op = MUL_INTERP;
      ST_MHI:  mreq.op = MUL_HIGH;
      ST_MLO:  mreq.op = MUL_LOW;
      default: mreq.op = MUL_DELAY;
    endcase
  end

  tpds_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_a),
    .wdata (mem_wd),
    .rdata (mem_rd)
  );

  tpds_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_step_r <= '0;
      grain_r      <= GRAIN_RESET;
      cursor_r     <= '0;
      full_r       <= 1'b0;
      phase_r      <= '0;
      tap_r        <= 1'b0;
      ch_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PHASE_STEP) begin
          phase_step_r <= cfg_data[PHASE_W-1:0];
        end else if (cfg_index == CFG_GRAIN_LENGTH) begin
          grain_r <= cfg_data[GRAIN_W-1:0];
        end
      end

      // a new result loaded in the same cycle keeps tvalid high
      if (out_tvalid_r && out_tready && !fin_go) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            smp0_r   <= in_tdata[SAMPLE_W-1:0];
            smp1_r   <= in_tdata[TDATA_W-1:SAMPLE_W];
            wa_r     <= weight_of(phase_r);
            wb_r     <= weight_of(phase_r + HALF);
            acc_r[0] <= '0;
            acc_r[1] <= '0;
            tap_r    <= 1'b0;
            ch_r     <= 1'b0;
            state_r  <= ST_WR0;
          end
        end
        ST_WR0:  state_r <= (CHANNELS > 1) ? ST_WR1 : ST_DLY;
        ST_WR1:  state_r <= ST_DLY;
        ST_DLY:  state_r <= ST_POS;
        ST_POS: begin
          i1_r    <= pos[POS_W-1:FRAC_W];
          frac_r  <= pos[FRAC_W-1:0];
          ch_r    <= 1'b0;
          state_r <= ST_RD1;
        end
        ST_RD1: begin
          rd_ok_r <= rd_frame_ok;
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          s1_r    <= rd_smp;
          rd_ok_r <= rd_frame_ok;
          state_r <= ST_RDW;
        end
        ST_RDW: begin
          diff_r  <= DIFF_W'(rd_smp) - DIFF_W'(s1_r);
          state_r <= ST_INT;
        end
        ST_INT:  state_r <= ST_INTW;
        ST_INTW: begin
          // s1 * 2^16 + f * (s2 - s1), Q1.39
          val_r   <= {s1_r[SAMPLE_W-1], s1_r, {FRAC_W{1'b0}}} + prod[VAL_W-1:0];
          state_r <= ST_MHI;
        end
        ST_MHI:  state_r <= ST_MLO;
        ST_MLO: begin
          acc_r[ch_r] <= acc_r[ch_r] + (ACC_W'(prod) <<< FRAC_W);
          state_r     <= ST_ACCL;
        end
        ST_ACCL: begin
          acc_r[ch_r] <= acc_r[ch_r] + ACC_W'(prod);
          if (ch_r != CH_LAST) begin
            ch_r    <= ch_r + 1'b1;
            state_r <= ST_RD1;
          end else if (!tap_r) begin
            tap_r   <= 1'b1;
            state_r <= ST_DLY;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_tdata_r  <= {round_sat(acc_r[1]), round_sat(acc_r[0])};
            out_tvalid_r <= 1'b1;
            cursor_r     <= cursor_inc;
            if (cursor_inc == '0) begin
              full_r <= 1'b1;
            end
            phase_r      <= phase_r + phase_step_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // cursor advances by one exactly when a result is loaded
  `TPDS_ASSERT_NXT(a_cursor_step, fin_go, cursor_r == $past(cursor_inc), "bad cursor step")
  // phase moves by the step when a result is loaded
  `TPDS_ASSERT_NXT(a_phase_step, fin_go, phase_r == $past(phase_r + phase_step_r), "bad phase")
  // the last step is reached only after both taps and all channels
  `TPDS_ASSERT_IMP(a_fin_order, state_r == ST_FIN, tap_r && (ch_r == CH_LAST), "bad order")
  // the store is written only before any tap is read
  `TPDS_ASSERT_IMP(a_write_first, mem_we, !tap_r && (ch_r == 1'b0), "late store write")

endmodule

`default_nettype wire
